// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker in rtl/pbrd_sva.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the default clk_i / rst_ni pair.
`define ASSERT_DEF(name, prop, msg) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/pbrd_pkg.sv -----
package pbrd_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned GAP_W          = 16;
  localparam int unsigned RATE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned WINDOW_DEFAULT = 16;
  localparam int unsigned DIVISOR_W      = TIME_W;

  localparam logic [GAP_W-1:0]    MIN_GAP_RESET  = 16'd800;
  localparam logic [RATE_W-1:0]   MIN_RATE_RESET = 8'd35;
  localparam logic [RATE_W-1:0]   MAX_RATE_RESET = 8'd200;
  // ms per minute, numerator of the rate division
  localparam logic [SAMPLE_W-1:0] BPM_NUMERATOR  = 16'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP  = 2'd0,
    CFG_MIN_RATE = 2'd1,
    CFG_MAX_RATE = 2'd2
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // input transfer: latch item, read ring slot, start mean division
    logic decide;      // mean ready: evaluate crossing
    logic start_rate;  // start 60000 / gap division
    logic commit;      // update state, load output register
  } pbrd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic need_rate;
    logic out_free;
  } pbrd_status_t;

endpackage

// ----- rtl/pbrd_if.sv -----
// Input channel: one sample with its timestamp.
interface pbrd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic [31:0] time_ms;

  modport source (output valid, sample, time_ms, input ready);
  modport sink   (input valid, sample, time_ms, output ready);
endinterface

// Output channel: beat flag and rate.
interface pbrd_out_if;
  logic       valid;
  logic       ready;
  logic       beat;
  logic       rate_valid;
  logic [7:0] rate_bpm;

  modport source (output valid, beat, rate_valid, rate_bpm, input ready);
  modport sink   (input valid, beat, rate_valid, rate_bpm, output ready);
endinterface

// ----- rtl/pbrd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pbrd_div #(
  parameter int unsigned DIVIDEND_W = 20,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // one trial subtraction per step
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/pbrd_ctrl.sv -----
// Sequencer: one item at a time through mean, crossing check, optional rate.
module pbrd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pbrd_pkg::pbrd_status_t status_i,
  output pbrd_pkg::pbrd_cmd_t    cmd_o
);
  import pbrd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN,
    S_CHECK,
    S_RATE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  pbrd_cmd_t cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_MEAN;
        end
      end
      S_MEAN: begin
        if (status_i.div_done) begin
          cmd.decide = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.need_rate) begin
          cmd.start_rate = 1'b1;
          state_d        = S_RATE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RATE: begin
        if (status_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

endmodule

// ----- rtl/pbrd_datapath.sv -----
// Ring, running sum, crossing logic, config registers and output register.
module pbrd_datapath #(
  parameter int unsigned WINDOW = pbrd_pkg::WINDOW_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pbrd_pkg::pbrd_cmd_t              cmd_i,
  output pbrd_pkg::pbrd_status_t           status_o,
  input  logic [pbrd_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [pbrd_pkg::TIME_W-1:0]      time_ms_i,
  input  logic                             cfg_we_i,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_beat_o,
  output logic                             out_rate_valid_o,
  output logic [pbrd_pkg::RATE_W-1:0]      out_rate_bpm_o
);
  import pbrd_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + SLOT_W;
  localparam int unsigned DIV_W  = (SUM_W > SAMPLE_W) ? SUM_W : SAMPLE_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

  // configuration registers
  logic [GAP_W-1:0]  min_gap_q;
  logic [RATE_W-1:0] min_rate_q;
  logic [RATE_W-1:0] max_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q  <= MIN_GAP_RESET;
      min_rate_q <= MIN_RATE_RESET;
      max_rate_q <= MAX_RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_GAP:  min_gap_q  <= cfg_wdata_i[GAP_W-1:0];
        CFG_MIN_RATE: min_rate_q <= cfg_wdata_i[RATE_W-1:0];
        CFG_MAX_RATE: max_rate_q <= cfg_wdata_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [SAMPLE_W-1:0] sample_q;
  logic [TIME_W-1:0]   time_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      time_q   <= time_ms_i;
    end
  end

  // detector state
  logic [SLOT_W-1:0] slot_q;
  logic [FILL_W-1:0] fill_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              below_q;
  logic [TIME_W-1:0] last_q;
  logic              beat_q;
  logic              need_q;

  // sample ring; slots not yet written are covered by the fill count
  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_q;
  logic [SAMPLE_W-1:0] old_sample;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ring_mem[slot_q] <= sample_q;
    end
    if (cmd_i.load) begin
      rd_q <= ring_mem[slot_q];
    end
  end

  assign old_sample = (fill_q == FILL_FULL) ? rd_q : '0;
  assign sum_d      = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);

  // shared divider: sum / fill, then 60000 / gap
  logic [DIV_W-1:0]     quot;
  logic                 div_done;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [TIME_W-1:0]    gap;

  assign gap          = time_q - last_q;
  assign div_start    = cmd_i.load | cmd_i.start_rate;
  assign div_dividend = cmd_i.start_rate ? DIV_W'(BPM_NUMERATOR) : DIV_W'(sum_q);
  assign div_divisor  = cmd_i.start_rate ? DIVISOR_W'(gap) :
                        (fill_q == '0) ? DIVISOR_W'(1) : DIVISOR_W'(fill_q);

  pbrd_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DIVISOR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // crossing decision against the mean
  logic above, under, beat_d, need_d, rate_ok;

  assign above   = DIV_W'(sample_q) > quot;
  assign under   = DIV_W'(sample_q) < quot;
  assign beat_d  = above & below_q;
  assign need_d  = beat_d & (gap > TIME_W'(min_gap_q)) & (last_q != '0);
  assign rate_ok = need_q & (quot >= DIV_W'(min_rate_q)) & (quot <= DIV_W'(max_rate_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      below_q <= 1'b0;
      last_q  <= '0;
      beat_q  <= 1'b0;
      need_q  <= 1'b0;
    end else begin
      if (cmd_i.decide) begin
        beat_q <= beat_d;
        need_q <= need_d;
        if (beat_d) begin
          below_q <= 1'b0;
        end else if (under) begin
          below_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        sum_q  <= sum_d;
        slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        if (beat_q) begin
          last_q <= time_q;
        end
      end
    end
  end

  // output register
  logic              out_valid_q;
  logic              out_beat_q;
  logic              out_rv_q;
  logic [RATE_W-1:0] out_bpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_beat_q <= beat_q;
      out_rv_q   <= rate_ok;
      out_bpm_q  <= rate_ok ? quot[RATE_W-1:0] : '0;
    end
  end

  assign status_o.div_done  = div_done;
  assign status_o.need_rate = need_q;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_beat_o       = out_beat_q;
  assign out_rate_valid_o = out_rv_q;
  assign out_rate_bpm_o   = out_bpm_q;

endmodule

// ----- rtl/pulse_beat_rate_detector_core.sv -----
// Pulse beat and rate detector.
// in_i carries one brightness sample and its millisecond timestamp per
// transfer; out_o returns exactly one result per input: beat flag, rate_valid
// and rate_bpm (zero unless rate_valid). Configuration (min gap, min/max rate)
// is written through cfg_we_i / cfg_idx_i / cfg_wdata_i, by the user only
// while no item is in flight; the block has no check for it. Unknown indexes
// are ignored. Each item is compared with the mean of up to WINDOW earlier
// samples, then, on an upward crossing with a prior beat and a long enough
// gap, 60000/gap is computed. Both divisions share one bit-serial divider:
// the mean division, then the rate division when one is needed, run between
// the input transfer and the output register load. One item is processed at
// a time; the next input transfer can follow in the cycle after that load.
// The finished result sits in an output register, and the next item is
// accepted while it waits; if out_o is stalled, the following item stops
// just before its result would load and the input stays blocked.
// Reset (rst_ni, asynchronous, active low) restores the default limits,
// empties the ring and forgets the last beat; no clearing pass is needed.
module pulse_beat_rate_detector_core #(
  parameter int unsigned WINDOW = pbrd_pkg::WINDOW_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pbrd_in_if.sink                         in_i,
  pbrd_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pbrd_pkg::*;

  pbrd_cmd_t    cmd;
  pbrd_status_t status;
  logic         in_ready;

  pbrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbrd_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_i         (in_i.sample),
    .time_ms_i        (in_i.time_ms),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_beat_o       (out_o.beat),
    .out_rate_valid_o (out_o.rate_valid),
    .out_rate_bpm_o   (out_o.rate_bpm)
  );

  assign in_i.ready = in_ready;

endmodule

// ----- rtl/pbrd_sva.sv -----
`include "assert_macros.svh"

// Port-level checks on the detector.
module pbrd_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_beat_i,
  input logic       out_rate_valid_i,
  input logic [7:0] out_rate_bpm_i
);

  // result holds until its transfer
  `ASSERT_DEF(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  // one item in flight: input closes right after a transfer
  `ASSERT_DEF(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i, "second item accepted in flight")

  // a rate is only reported on a beat
  `ASSERT_DEF(a_rate_on_beat, out_valid_i && out_rate_valid_i |-> out_beat_i, "rate without beat")

  // rate field is zero when not reported
  `ASSERT_DEF(a_rate_zero, out_valid_i && !out_rate_valid_i |-> out_rate_bpm_i == 8'd0, "stray rate value")

endmodule

bind pulse_beat_rate_detector_core pbrd_sva u_pbrd_sva (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_beat_i       (out_o.beat),
  .out_rate_valid_i (out_o.rate_valid),
  .out_rate_bpm_i   (out_o.rate_bpm)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pbrd_pkg::*;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned IDLE_MODES   = 4;
  localparam int unsigned SEG_ITEMS    = 97;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic       beat;
    logic       rate_valid;
    logic [7:0] rate_bpm;
  } pulse_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
  } frame_t;

  // Predicts beat/rate per sample and tracks the results still owed
  class beat_rate_model;
    logic [GAP_W-1:0]    min_gap;
    logic [RATE_W-1:0]   min_rate;
    logic [RATE_W-1:0]   max_rate;
    logic [SAMPLE_W-1:0] hist [WINDOW_DEFAULT];
    int unsigned         hist_slot;
    int unsigned         hist_count;
    bit                  dipped;
    logic [TIME_W-1:0]   prev_beat_ms;
    pulse_result_t       owed[$];
    int unsigned         mismatches;

    function new();
      min_gap      = MIN_GAP_RESET;
      min_rate     = MIN_RATE_RESET;
      max_rate     = MAX_RATE_RESET;
      foreach (hist[i]) hist[i] = '0;
      hist_slot    = 0;
      hist_count   = 0;
      dipped       = 1'b0;
      prev_beat_ms = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_GAP:  min_gap  = data[GAP_W-1:0];
        CFG_MIN_RATE: min_rate = data[RATE_W-1:0];
        CFG_MAX_RATE: max_rate = data[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    // integer mean of the filled entries, divisor at least one
    function logic [31:0] window_avg();
      logic [31:0] sum;
      sum = '0;
      for (int unsigned i = 0; i < hist_count; i++) sum += 32'(hist[i]);
      return (hist_count == 0) ? sum : sum / hist_count;
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now);
      logic [31:0]   avg;
      logic [31:0]   gap;
      logic [31:0]   rate;
      pulse_result_t r;
      avg = window_avg();
      r   = '0;
      if (smp > avg && dipped) begin
        gap    = now - prev_beat_ms;
        r.beat = 1'b1;
        if (gap > min_gap && prev_beat_ms != 0) begin
          rate = 32'(BPM_NUMERATOR) / gap;
          if (rate >= min_rate && rate <= max_rate) begin
            r.rate_valid = 1'b1;
            r.rate_bpm   = rate[7:0];
          end
        end
        prev_beat_ms = now;
        dipped       = 1'b0;
      end else if (smp < avg) begin
        dipped = 1'b1;
      end
      hist[hist_slot] = smp;
      hist_slot = (hist_slot + 1) % WINDOW_DEFAULT;
      if (hist_count < WINDOW_DEFAULT) hist_count++;
      owed.push_back(r);
    endfunction

    function void match_result(pulse_result_t got);
      pulse_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: beat=%0b rate_valid=%0b rate_bpm=%0d",
                   got.beat, got.rate_valid, got.rate_bpm);
        return;
      end
      want = owed.pop_front();
      if (got.beat !== want.beat || got.rate_valid !== want.rate_valid ||
          got.rate_bpm !== want.rate_bpm) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: exp beat=%0b rv=%0b bpm=%0d, got beat=%0b rv=%0b bpm=%0d",
                   want.beat, want.rate_valid, want.rate_bpm,
                   got.beat, got.rate_valid, got.rate_bpm);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pbrd_in_if  in_bus ();
  pbrd_out_if out_bus ();

  pulse_beat_rate_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  beat_rate_model model = new();

  frame_t      outgoing[$];
  bit          offered;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_request;
  logic [31:0] wave_clock;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Input side: present queued frames, idle at random between them
  initial begin
    frame_t f;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    in_bus.time_ms = '0;
    offered        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (in_bus.valid && in_bus.ready) begin
        model.take_sample(in_bus.sample, in_bus.time_ms);
        offered = 1'b0;
      end
      @(negedge clk_i);
      if (!offered) begin
        if (rst_ni && outgoing.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          f = outgoing.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.sample  <= f.sample;
          in_bus.time_ms <= f.time_ms;
          offered = 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      model.match_result('{out_bus.beat, out_bus.rate_valid, out_bus.rate_bpm});
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    model.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_sent();
    while (outgoing.size() != 0 || offered) @(negedge clk_i);
  endtask

  task automatic settle();
    while (outgoing.size() != 0 || offered || model.owed.size() != 0) @(negedge clk_i);
  endtask

  // Mostly square-ish pulse trains of random period, level and frame spacing;
  // the rest is noise with random samples and, half the time, random timestamps.
  task automatic queue_pulse_train(input int unsigned count);
    int unsigned         frames, frame_ms, frame_idx, burst_left;
    logic [SAMPLE_W-1:0] lo, hi, smp;
    logic [TIME_W-1:0]   stamp;
    burst_left = 0;
    frames     = 4;
    frame_ms   = 20;
    frame_idx  = 0;
    lo         = '0;
    hi         = '0;
    for (int unsigned k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(120, 20);
        frames     = $urandom_range(30, 4);
        frame_ms   = $urandom_range(60, 8);
        hi         = 16'($urandom_range(65535, 2048));
        lo         = 16'($urandom_range(hi - 1024, 0));
        frame_idx  = 0;
        case ($urandom_range(3))
          0: wave_clock = $urandom();
          1: wave_clock = 32'hFFFF_FFFF - $urandom_range(4000);
          default: ;
        endcase
      end
      burst_left--;
      wave_clock += frame_ms + $urandom_range(3);
      if ($urandom_range(99) < 15) begin
        smp   = 16'($urandom());
        stamp = $urandom_range(1) ? $urandom() : wave_clock;
      end else begin
        // first half of the period high, second half low, small jitter
        smp   = (frame_idx < frames / 2) ? 16'(hi - $urandom_range(255)) :
                                           16'(lo + $urandom_range(255));
        stamp = wave_clock;
      end
      frame_idx = (frame_idx + 1) % frames;
      outgoing.push_back('{smp, stamp});
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_request    = 0;
    wave_clock      = 32'd1000;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty ring, extremes, crossings, gaps and timestamp wrap
    outgoing.push_back('{16'h0000, 32'd100});    // empty ring: equal to mean
    outgoing.push_back('{16'hFFFF, 32'd133});    // above, never dipped
    outgoing.push_back('{16'h0000, 32'd166});
    outgoing.push_back('{16'hFFFF, 32'd0});      // beat at time zero
    outgoing.push_back('{16'h0000, 32'd200});
    outgoing.push_back('{16'hFFFF, 32'd5000});   // no earlier beat on record
    outgoing.push_back('{16'h0000, 32'd5100});
    outgoing.push_back('{16'hFFFF, 32'd6000});   // 1000 ms gap
    wait_sent();
    outgoing.push_back('{16'(model.window_avg()), 32'd6100});
    outgoing.push_back('{16'h0000, 32'd6200});
    wait_sent();
    outgoing.push_back('{16'(model.window_avg()), 32'd6300});  // equal while dipped
    wait_sent();
    outgoing.push_back('{16'(model.window_avg() + 1), 32'd6700});  // gap too short
    outgoing.push_back('{16'h0000, 32'd6750});
    outgoing.push_back('{16'hFFFF, 32'hFFFF_FF00});
    outgoing.push_back('{16'h0000, 32'hFFFF_FF80});
    outgoing.push_back('{16'hFFFF, 32'd1000});   // gap across the wrap
    outgoing.push_back('{16'h0000, 32'd1500});
    outgoing.push_back('{16'hFFFF, 32'd1800});   // gap equal to min gap
    outgoing.push_back('{16'h0000, 32'd1900});
    outgoing.push_back('{16'hFFFF, 32'd2601});   // one past min gap

    // Random phases, each under its own limits and every idle mode
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1: begin
          write_cfg(CFG_MIN_GAP, 16'd0);
          write_cfg(CFG_MIN_RATE, 16'hA500);
          write_cfg(CFG_MAX_RATE, 16'h00FF);
          write_cfg(CFG_UNUSED_IDX, 16'h1234);
        end
        2: begin
          write_cfg(CFG_MIN_GAP, 16'hFFFF);
          write_cfg(CFG_MIN_RATE, 16'h00FF);
          write_cfg(CFG_MAX_RATE, 16'hFFFF);
        end
        3: begin
          // inverted limits
          write_cfg(CFG_MIN_GAP, 16'd100);
          write_cfg(CFG_MIN_RATE, 16'd150);
          write_cfg(CFG_MAX_RATE, 16'd50);
        end
        4: begin
          write_cfg(CFG_MIN_GAP, 16'd300);
          write_cfg(CFG_MIN_RATE, {8'($urandom()), 8'd40});
          write_cfg(CFG_MAX_RATE, {8'($urandom()), 8'd180});
        end
        default: ;
      endcase
      for (int unsigned m = 0; m < IDLE_MODES; m++) begin
        case (m)
          0: begin sender_idle_pct = 0;  stall_pct = 0;  end
          1: begin sender_idle_pct = 58; stall_pct = 0;  end
          2: begin sender_idle_pct = 0;  stall_pct = 58; end
          default: begin sender_idle_pct = 10; stall_pct = 10; end
        endcase
        // long output hold-off so the block backs up into its input
        if (p == 2 && m == 0) hold_request = HOLD_CYCLES;
        queue_pulse_train(SEG_ITEMS);
        wait_sent();
      end
    end

    settle();
    repeat (64) @(negedge clk_i);
    if (model.owed.size() != 0) begin
      $display("%0d results never arrived", model.owed.size());
      model.mismatches++;
    end
    if (model.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- pulse_beat_rate_detector_core.f -----
+incdir+rtl
rtl/pbrd_pkg.sv
rtl/pbrd_if.sv
rtl/pbrd_div.sv
rtl/pbrd_ctrl.sv
rtl/pbrd_datapath.sv
rtl/pulse_beat_rate_detector_core.sv
rtl/pbrd_sva.sv
verif/testbench.sv
